### rtl/knnhs_pkg.sv
// shared types and constants of the bounded max-heap top-k selector
`default_nettype none

package knnhs_pkg;

  localparam int MAX_NEIGHBOURS = 32;
  localparam int IDX_W = $clog2(MAX_NEIGHBOURS);
  localparam int N_W = $clog2(MAX_NEIGHBOURS + 1);

  localparam int FUNC_W = 2;
  localparam int DIST_W = 32;
  localparam int PIDX_W = 24;
  localparam int POINT_W = 25;
  localparam int COUNT_W = 32;
  localparam int SIZE_W = 6;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_RADIUS = 1'd1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic signed [POINT_W-1:0] point;
  } entry_t;

  localparam int ENTRY_W = DIST_W + POINT_W;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t wr_data;
  } store_req_t;

endpackage

`default_nettype wire

### rtl/knnhs_if.sv
// valid/ready channels for candidate requests and heap results
`default_nettype none

interface knnhs_in_if;
  logic valid;
  logic ready;
  logic [knnhs_pkg::FUNC_W-1:0] func;
  logic [knnhs_pkg::DIST_W-1:0] distance;
  logic [knnhs_pkg::PIDX_W-1:0] point_index;

  modport source(output valid, func, distance, point_index, input ready);
  modport sink(input valid, func, distance, point_index, output ready);
endinterface

interface knnhs_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic [knnhs_pkg::DIST_W-1:0] entry_distance;
  logic signed [knnhs_pkg::POINT_W-1:0] entry_index;
  logic [knnhs_pkg::COUNT_W-1:0] offers_seen;
  logic last;

  modport source(output valid, accepted, entry_distance, entry_index, offers_seen, last,
                 input ready);
  modport sink(input valid, accepted, entry_distance, entry_index, offers_seen, last,
               output ready);
endinterface

`default_nettype wire

### rtl/knnhs_ram.sv
// generic ram: one write port, two read ports with registered read data
`default_nettype none

module knnhs_ram #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/knnhs_store.sv
// heap storage: ram plus per-entry valid bits, fill radius and cached root
`default_nettype none

module knnhs_store (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire knnhs_pkg::store_req_t           req,
  input  wire logic [knnhs_pkg::DIST_W-1:0]    radius,
  output knnhs_pkg::entry_t                    rd_a,
  output knnhs_pkg::entry_t                    rd_b,
  output knnhs_pkg::entry_t                    root
);

  logic [knnhs_pkg::MAX_NEIGHBOURS-1:0] valid;
  logic [knnhs_pkg::DIST_W-1:0] fill;
  knnhs_pkg::entry_t root_q;
  knnhs_pkg::entry_t empty;
  logic valid_a;
  logic valid_b;
  logic [knnhs_pkg::ENTRY_W-1:0] raw_a;
  logic [knnhs_pkg::ENTRY_W-1:0] raw_b;

  knnhs_ram #(
    .WIDTH(knnhs_pkg::ENTRY_W),
    .DEPTH(knnhs_pkg::MAX_NEIGHBOURS)
  ) u_ram (
    .clk(clk),
    .we(req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .re(req.rd_en),
    .raddr_a(req.rd_addr_a),
    .raddr_b(req.rd_addr_b),
    .rdata_a(raw_a),
    .rdata_b(raw_b)
  );

  // a cleared entry reads as the fill radius with an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill <= '1;
    end else if (req.clear) begin
      valid <= '0;
      fill <= radius;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      valid_a <= valid[req.rd_addr_a];
      valid_b <= valid[req.rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_addr == '0) begin
      root_q <= req.wr_data;
    end
  end

  always_comb begin
    empty.distance = fill;
    empty.point = '1;
    rd_a = valid_a ? knnhs_pkg::entry_t'(raw_a) : empty;
    rd_b = valid_b ? knnhs_pkg::entry_t'(raw_b) : empty;
    root = valid[0] ? root_q : empty;
  end

endmodule

`default_nettype wire

### rtl/knnhs_core.sv
// request sequencer, sift-down walk and result register of the heap selector
`default_nettype none

// Bounded max-heap top-k selector.
// cand channel: one beat per request, func selects offer, clear or readout.
// resp channel: result beats, last marks the final beat of a request.
// wr_en/wr_index/wr_data write active_size (index 0) or initial_radius
// (index 1); write them only while the block is idle.
// A request is taken only while the sequencer is idle, one at a time.
// Offer: the root is held in a register, so the compare happens at the
// accepting edge; at each sift level the children are read from the
// dual-read ram while the parent slot is written, then the candidate is
// written into the slot where it stops and the result register is loaded.
// A rejected offer goes straight to the result load.
// Clear: valid bits drop at once when the request is taken.
// Readout: one ram read per entry, n beats.
// Results sit in an output register; the next request is taken while a
// result waits, and the block holds in its response step when the receiver
// stalls. Reset empties the heap (all-ones distances, empty slots), zeroes the
// offer counter and loads active_size 32 and radius all ones; no sweep.
module knnhs_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  knnhs_in_if.sink                                  cand,
  knnhs_out_if.source                               resp,
  input  wire logic                                 wr_en,
  input  wire logic [knnhs_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  wire logic [knnhs_pkg::CFG_DATA_W-1:0]     wr_data
);

  localparam int IDX_W = knnhs_pkg::IDX_W;
  localparam int N_W = knnhs_pkg::N_W;
  localparam int CW = IDX_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SIFT = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [IDX_W-1:0] s;
  logic [IDX_W-1:0] s_next;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] i_next;
  logic [N_W-1:0] n_q;
  logic [N_W-1:0] n_live;
  knnhs_pkg::entry_t cur;
  logic acc_q;
  logic [knnhs_pkg::COUNT_W-1:0] offer_count;
  logic [knnhs_pkg::SIZE_W-1:0] active_size;
  logic [knnhs_pkg::DIST_W-1:0] initial_radius;

  knnhs_pkg::store_req_t req;
  knnhs_pkg::entry_t rd_a;
  knnhs_pkg::entry_t rd_b;
  knnhs_pkg::entry_t root;

  logic take;
  logic offer_hit;
  logic out_free;
  logic load_resp;
  logic load_read;
  logic last_rd;
  logic [CW-1:0] c1;
  logic [CW-1:0] c2;
  logic has_c2;
  logic pick_b;
  knnhs_pkg::entry_t pick;
  logic [IDX_W-1:0] j;
  logic [CW-1:0] jc1;

  logic out_valid;
  logic out_accepted;
  logic [knnhs_pkg::DIST_W-1:0] out_distance;
  logic signed [knnhs_pkg::POINT_W-1:0] out_index;
  logic [knnhs_pkg::COUNT_W-1:0] out_seen;
  logic out_last;

  knnhs_store u_store (
    .clk(clk),
    .rst(rst),
    .req(req),
    .radius(initial_radius),
    .rd_a(rd_a),
    .rd_b(rd_b),
    .root(root)
  );

  assign cand.ready = (state == S_IDLE);
  assign take = cand.valid && cand.ready;
  assign out_free = !out_valid || resp.ready;
  assign offer_hit = !(cand.distance > root.distance);

  always_comb begin
    if (active_size == '0) begin
      n_live = N_W'(1);
    end else if (int'(active_size) > knnhs_pkg::MAX_NEIGHBOURS) begin
      n_live = N_W'(knnhs_pkg::MAX_NEIGHBOURS);
    end else begin
      n_live = N_W'(active_size);
    end
  end

  // children of the current slot, read in the previous cycle
  always_comb begin
    c1 = CW'({s, 1'b1});
    c2 = c1 + CW'(1);
    has_c2 = c2 < CW'(n_q);
    pick_b = has_c2 && (rd_a.distance < rd_b.distance);
    pick = pick_b ? rd_b : rd_a;
    j = pick_b ? c2[IDX_W-1:0] : c1[IDX_W-1:0];
    jc1 = CW'({j, 1'b1});
    last_rd = (N_W'(i) + N_W'(1)) == n_q;
  end

  always_comb begin
    req = '0;
    state_next = state;
    s_next = s;
    i_next = i;
    load_resp = 1'b0;
    load_read = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (cand.func)
            knnhs_pkg::FUNC_OFFER: begin
              if (offer_hit) begin
                s_next = '0;
                if (N_W'(1) < n_live) begin
                  req.rd_en = 1'b1;
                  req.rd_addr_a = IDX_W'(1);
                  req.rd_addr_b = IDX_W'(2);
                  state_next = S_SIFT;
                end else begin
                  state_next = S_LAST;
                end
              end else begin
                state_next = S_RESP;
              end
            end
            knnhs_pkg::FUNC_CLEAR: begin
              req.clear = 1'b1;
              state_next = S_RESP;
            end
            knnhs_pkg::FUNC_READ: begin
              req.rd_en = 1'b1;
              req.rd_addr_a = '0;
              req.rd_addr_b = '0;
              i_next = '0;
              state_next = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SIFT: begin
        req.wr_en = 1'b1;
        req.wr_addr = s;
        if (cur.distance < pick.distance) begin
          // larger child moves up, the candidate goes on down
          req.wr_data = pick;
          s_next = j;
          if (jc1 < CW'(n_q)) begin
            req.rd_en = 1'b1;
            req.rd_addr_a = jc1[IDX_W-1:0];
            req.rd_addr_b = IDX_W'(jc1 + CW'(1));
          end else begin
            state_next = S_LAST;
          end
        end else begin
          req.wr_data = cur;
          state_next = S_RESP;
        end
      end
      S_LAST: begin
        req.wr_en = 1'b1;
        req.wr_addr = s;
        req.wr_data = cur;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          load_resp = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          load_read = 1'b1;
          if (last_rd) begin
            state_next = S_IDLE;
          end else begin
            i_next = i + IDX_W'(1);
            req.rd_en = 1'b1;
            req.rd_addr_a = i + IDX_W'(1);
            req.rd_addr_b = i + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      offer_count <= '0;
      active_size <= knnhs_pkg::SIZE_W'(knnhs_pkg::MAX_NEIGHBOURS);
      initial_radius <= '1;
    end else begin
      state <= state_next;
      if (take && cand.func == knnhs_pkg::FUNC_OFFER && offer_count != '1) begin
        offer_count <= offer_count + knnhs_pkg::COUNT_W'(1);
      end else if (take && cand.func == knnhs_pkg::FUNC_CLEAR) begin
        offer_count <= '0;
      end
      if (wr_en) begin
        case (wr_index)
          knnhs_pkg::REG_ACTIVE_SIZE: active_size <= wr_data[knnhs_pkg::SIZE_W-1:0];
          knnhs_pkg::REG_INITIAL_RADIUS: initial_radius <= wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s <= s_next;
    i <= i_next;
    if (take) begin
      n_q <= n_live;
      acc_q <= (cand.func == knnhs_pkg::FUNC_OFFER) && offer_hit;
      cur.distance <= cand.distance;
      cur.point <= knnhs_pkg::POINT_W'({1'b0, cand.point_index});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_resp || load_read) begin
      out_valid <= 1'b1;
    end else if (resp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_resp) begin
      out_accepted <= acc_q;
      out_distance <= root.distance;
      out_index <= root.point;
      out_seen <= offer_count;
      out_last <= 1'b1;
    end else if (load_read) begin
      out_accepted <= 1'b0;
      out_distance <= rd_a.distance;
      out_index <= rd_a.point;
      out_seen <= offer_count;
      out_last <= last_rd;
    end
  end

  assign resp.valid = out_valid;
  assign resp.accepted = out_accepted;
  assign resp.entry_distance = out_distance;
  assign resp.entry_index = out_index;
  assign resp.offers_seen = out_seen;
  assign resp.last = out_last;

  a_accept_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_accepted) |-> out_last)
    else $error("accepted offer result not marked last");

  a_sift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIFT || state == S_LAST) |-> (N_W'(s) < n_q))
    else $error("sift slot beyond heap size");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (N_W'(i) < n_q))
    else $error("readout index beyond heap size");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    req.clear |-> !req.wr_en && !req.rd_en)
    else $error("heap access during clear");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(offer_count) == '1 && !$past(req.clear)) |-> offer_count == '1)
    else $error("offer counter wrapped");

endmodule

`default_nettype wire

### rtl/knn_bounded_max_heap_select_core.sv
// top level of the bounded max-heap top-k selector
`default_nettype none

// Bounded max-heap top-k selector, top level.
// cand channel (valid/ready): func 0 offers (distance, point_index), func 1
// clears the heap, func 2 reads all active entries out; func 3 is dropped.
// resp channel (valid/ready): one beat per offer or clear, n beats per
// readout in heap-array order, last set on the final beat of a request.
// Config port: wr_en with wr_index 0 writes active_size, index 1 writes
// initial_radius; a write is taken on any edge with wr_en high.
// One request at a time. Offer: compare against the registered root on the
// accepting edge, then at each sift level the dual-read ram gives both
// children while the parent slot is written; the candidate is written where
// it stops and the result is loaded. A rejected offer goes to the result load.
// Clear: valid bits drop at once. Readout: one ram read per entry.
// Results wait in an output register; the block takes the next request
// while one waits and holds in its response step while resp stalls.
// Reset empties the heap to all-ones distances and empty slots, zeroes
// the offer count, and sets active_size 32 and radius all ones.
module knn_bounded_max_heap_select_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  knnhs_in_if.sink                                  cand,
  knnhs_out_if.source                               resp,
  input  wire logic                                 wr_en,
  input  wire logic [knnhs_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  wire logic [knnhs_pkg::CFG_DATA_W-1:0]     wr_data
);

  knnhs_core u_core (
    .clk(clk),
    .rst(rst),
    .cand(cand),
    .resp(resp),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for the bounded max-heap top-k selector, checked beat by beat
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 42;

  typedef struct packed {
    logic accepted;
    logic [knnhs_pkg::DIST_W-1:0] distance;
    logic signed [knnhs_pkg::POINT_W-1:0] point;
    logic [knnhs_pkg::COUNT_W-1:0] seen;
    logic last;
  } heap_beat_t;

  class topk_tracker;
    logic [knnhs_pkg::DIST_W-1:0] dist_q[knnhs_pkg::MAX_NEIGHBOURS];
    logic signed [knnhs_pkg::POINT_W-1:0] point_q[knnhs_pkg::MAX_NEIGHBOURS];
    logic [knnhs_pkg::COUNT_W-1:0] offer_cnt;
    logic [knnhs_pkg::SIZE_W-1:0] size_reg;
    logic [knnhs_pkg::DIST_W-1:0] radius_reg;
    heap_beat_t pending_beats[$];
    int errors;

    function new();
      fill_heap('1);
      offer_cnt = '0;
      size_reg = knnhs_pkg::SIZE_W'(knnhs_pkg::MAX_NEIGHBOURS);
      radius_reg = '1;
      errors = 0;
    endfunction

    function void fill_heap(logic [knnhs_pkg::DIST_W-1:0] d);
      for (int i = 0; i < knnhs_pkg::MAX_NEIGHBOURS; i++) begin
        dist_q[i] = d;
        point_q[i] = '1;
      end
    endfunction

    function int unsigned live_n();
      if (size_reg == 0) return 1;
      if (size_reg > knnhs_pkg::MAX_NEIGHBOURS) return knnhs_pkg::MAX_NEIGHBOURS;
      return size_reg;
    endfunction

    function void write_reg(logic [knnhs_pkg::CFG_INDEX_W-1:0] idx,
                            logic [knnhs_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        knnhs_pkg::REG_ACTIVE_SIZE: size_reg = val[knnhs_pkg::SIZE_W-1:0];
        knnhs_pkg::REG_INITIAL_RADIUS: radius_reg = val;
        default: ;
      endcase
    endfunction

    function void sift_root(int unsigned n);
      int unsigned s;
      int unsigned j;
      logic [knnhs_pkg::DIST_W-1:0] td;
      logic signed [knnhs_pkg::POINT_W-1:0] tp;
      bit done;
      s = 0;
      done = 0;
      while (!done && (2 * s + 1 < n)) begin
        j = 2 * s + 1;
        if (j + 1 < n && dist_q[j] < dist_q[j + 1]) j = j + 1;
        if (dist_q[s] < dist_q[j]) begin
          td = dist_q[s];
          tp = point_q[s];
          dist_q[s] = dist_q[j];
          point_q[s] = point_q[j];
          dist_q[j] = td;
          point_q[j] = tp;
          s = j;
        end else begin
          done = 1;
        end
      end
    endfunction

    function void note_request(logic [knnhs_pkg::FUNC_W-1:0] f,
                               logic [knnhs_pkg::DIST_W-1:0] d,
                               logic [knnhs_pkg::PIDX_W-1:0] p);
      heap_beat_t b;
      int unsigned n;
      n = live_n();
      case (f)
        knnhs_pkg::FUNC_OFFER: begin
          b.accepted = 1'b0;
          if (offer_cnt != '1) offer_cnt = offer_cnt + knnhs_pkg::COUNT_W'(1);
          if (!(d > dist_q[0])) begin
            dist_q[0] = d;
            point_q[0] = {1'b0, p};
            sift_root(n);
            b.accepted = 1'b1;
          end
          b.distance = dist_q[0];
          b.point = point_q[0];
          b.seen = offer_cnt;
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
        knnhs_pkg::FUNC_CLEAR: begin
          fill_heap(radius_reg);
          offer_cnt = '0;
          b = '{accepted: 1'b0, distance: dist_q[0], point: point_q[0], seen: '0,
                last: 1'b1};
          pending_beats.push_back(b);
        end
        knnhs_pkg::FUNC_READ: begin
          for (int unsigned i = 0; i < n; i++) begin
            b = '{accepted: 1'b0, distance: dist_q[i], point: point_q[i], seen: offer_cnt,
                  last: (i + 1 == n)};
            pending_beats.push_back(b);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(heap_beat_t got);
      heap_beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat acc=%0d dist=%h idx=%0d seen=%0d last=%0d",
                 $time, got.accepted, got.distance, got.point, got.seen, got.last);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.accepted !== want.accepted || got.distance !== want.distance ||
          got.point !== want.point || got.seen !== want.seen || got.last !== want.last) begin
        $display("%0t: mismatch expected acc=%0d dist=%h idx=%0d seen=%0d last=%0d",
                 $time, want.accepted, want.distance, want.point, want.seen, want.last);
        $display("%0t:          actual   acc=%0d dist=%h idx=%0d seen=%0d last=%0d",
                 $time, got.accepted, got.distance, got.point, got.seen, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  logic [knnhs_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [knnhs_pkg::CFG_DATA_W-1:0] wr_data;

  knnhs_in_if cand_ch();
  knnhs_out_if resp_ch();

  knn_bounded_max_heap_select_core dut (
    .clk(clk),
    .rst(rst),
    .cand(cand_ch),
    .resp(resp_ch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  topk_tracker tracker = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests = 0;
  int holds_served = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random stalls plus a long hold-off on request
  initial begin
    resp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        resp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      resp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (resp_ch.valid && resp_ch.ready)
        tracker.check_beat('{accepted: resp_ch.accepted, distance: resp_ch.entry_distance,
                             point: resp_ch.entry_index, seen: resp_ch.offers_seen,
                             last: resp_ch.last});
      if ((cand_ch.valid && cand_ch.ready) || (resp_ch.valid && resp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic [knnhs_pkg::FUNC_W-1:0] f,
                           logic [knnhs_pkg::DIST_W-1:0] d,
                           logic [knnhs_pkg::PIDX_W-1:0] p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cand_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cand_ch.valid <= 1'b1;
    cand_ch.func <= f;
    cand_ch.distance <= d;
    cand_ch.point_index <= p;
    do @(posedge clk); while (!cand_ch.ready);
    tracker.note_request(f, d, p);
  endtask

  task automatic offer(logic [knnhs_pkg::DIST_W-1:0] d, logic [knnhs_pkg::PIDX_W-1:0] p);
    send_item(knnhs_pkg::FUNC_OFFER, d, p);
  endtask

  // sender pauses until every expected beat is in, then lets the block settle
  task automatic await_idle();
    @(negedge clk);
    cand_ch.valid <= 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [knnhs_pkg::CFG_INDEX_W-1:0] idx,
                           logic [knnhs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [knnhs_pkg::CFG_DATA_W-1:0] pick_size();
    logic [knnhs_pkg::SIZE_W-1:0] sz;
    logic [knnhs_pkg::CFG_DATA_W-1:0] w;
    int r;
    r = $urandom_range(99);
    if (r < 60) sz = knnhs_pkg::SIZE_W'($urandom_range(8, 1));
    else if (r < 75) sz = knnhs_pkg::SIZE_W'(knnhs_pkg::MAX_NEIGHBOURS);
    else if (r < 85) sz = knnhs_pkg::SIZE_W'($urandom_range(31, 9));
    else if (r < 92) sz = '0;
    else sz = knnhs_pkg::SIZE_W'($urandom_range(63, 33));
    // upper bits of the write data are don't-care
    w = $urandom;
    w[knnhs_pkg::SIZE_W-1:0] = sz;
    return w;
  endfunction

  function automatic logic [knnhs_pkg::DIST_W-1:0] pick_radius();
    int r;
    r = $urandom_range(99);
    if (r < 30) return '1;
    if (r < 40) return '0;
    return $urandom;
  endfunction

  function automatic logic [knnhs_pkg::DIST_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2: return tracker.dist_q[0];
      3: return $urandom;
      default: return $urandom_range(tracker.radius_reg);
    endcase
  endfunction

  task automatic random_phase(int phase);
    int count;
    int r;
    write_reg(knnhs_pkg::REG_ACTIVE_SIZE, pick_size());
    write_reg(knnhs_pkg::REG_INITIAL_RADIUS, pick_radius());
    send_item(knnhs_pkg::FUNC_CLEAR, $urandom, knnhs_pkg::PIDX_W'($urandom));
    count = 0;
    while (count < ITEMS_PER_PHASE) begin
      if (count == 10 && phase != 1) hold_requests++;
      if (count == 30) begin
        await_idle();
        // resize without a clear now and then
        write_reg(knnhs_pkg::REG_ACTIVE_SIZE, pick_size());
        if ($urandom_range(1)) write_reg(knnhs_pkg::REG_INITIAL_RADIUS, pick_radius());
      end
      r = $urandom_range(99);
      if (r < 82) begin
        offer(pick_distance(), knnhs_pkg::PIDX_W'($urandom));
        count++;
      end else if (r < 90) begin
        send_item(knnhs_pkg::FUNC_READ, $urandom, knnhs_pkg::PIDX_W'($urandom));
        count++;
      end else if (r < 95) begin
        send_item(knnhs_pkg::FUNC_CLEAR, $urandom, knnhs_pkg::PIDX_W'($urandom));
        count++;
      end else begin
        send_item(knnhs_pkg::FUNC_UNUSED, $urandom, knnhs_pkg::PIDX_W'($urandom));
      end
    end
    await_idle();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    cand_ch.valid = 1'b0;
    cand_ch.func = '0;
    cand_ch.distance = '0;
    cand_ch.point_index = '0;
    tx_idle_pct = 13;
    rx_idle_pct = 47;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // heap straight out of reset, ties with the root, field extremes
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    offer('1, '1);
    offer('0, '0);
    offer(32'h8000_0000, 24'h80_0000);
    offer('1, 24'h12_3456);
    send_item(knnhs_pkg::FUNC_UNUSED, $urandom, knnhs_pkg::PIDX_W'($urandom));
    send_item(knnhs_pkg::FUNC_READ, '1, '1);
    await_idle();

    // single entry with zero radius
    write_reg(knnhs_pkg::REG_ACTIVE_SIZE, 1);
    write_reg(knnhs_pkg::REG_INITIAL_RADIUS, 0);
    send_item(knnhs_pkg::FUNC_CLEAR, '0, '0);
    offer(0, 24'h00_0001);
    offer(1, 24'h00_0002);
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    await_idle();

    // size zero behaves as one
    write_reg(knnhs_pkg::REG_ACTIVE_SIZE, 0);
    offer(0, 24'h55_aaaa);
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    await_idle();

    // oversize saturates to the full heap
    write_reg(knnhs_pkg::REG_ACTIVE_SIZE, 63);
    write_reg(knnhs_pkg::REG_INITIAL_RADIUS, 1000);
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    send_item(knnhs_pkg::FUNC_CLEAR, '0, '0);
    offer(999, 24'h00_0010);
    offer(5, 24'h00_0011);
    offer(1000, 24'h00_0012);
    offer(1001, 24'h00_0013);
    offer(500, 24'h00_0014);
    offer(10, 24'h00_0015);
    await_idle();

    // shrink without a clear
    write_reg(knnhs_pkg::REG_ACTIVE_SIZE, 5);
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    offer(3, 24'haa_5555);
    send_item(knnhs_pkg::FUNC_READ, '0, '0);
    send_item(knnhs_pkg::FUNC_CLEAR, '0, '0);
    await_idle();

    random_phase(0);
    tx_idle_pct = 47;
    rx_idle_pct = 13;
    random_phase(1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(2);

    await_idle();
    if (tracker.errors == 0 && tracker.pending_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
